### hdl/ortml_pkg.sv
// Shared types and constants for the ordered rule table merge and lookup block.
`default_nettype none

package ortml_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] PART_ANY = 3'd5;

  localparam logic FUNC_MERGE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_UNMATCHED = 2'd2;

  typedef struct packed {
    logic [2:0]  to_part;
    logic [2:0]  from_part;
    logic        net_is_any;
    logic [31:0] net_id;
  } key_t;

  typedef struct packed {
    logic [7:0]  hash;
    logic [31:0] word;
  } flav_t;

  typedef struct packed {
    key_t  key;
    flav_t flav;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic stop;
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_MRD,
    ST_MWR,
    ST_PUT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### hdl/ortml_if.sv
// Request and response channel interfaces.
`default_nettype none

interface ortml_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] net_id;
  logic        net_is_any;
  logic [2:0]  from_part;
  logic [2:0]  to_part;
  logic [31:0] flavor_word;
  logic        flavor_valid;
  logic [7:0]  hash_choice;
  logic        peer_is_loopback;

  modport source (
    output valid, func, net_id, net_is_any, from_part, to_part,
           flavor_word, flavor_valid, hash_choice, peer_is_loopback,
    input  ready
  );
  modport sink (
    input  valid, func, net_id, net_is_any, from_part, to_part,
           flavor_word, flavor_valid, hash_choice, peer_is_loopback,
    output ready
  );
endinterface

interface ortml_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic                        found;
  logic [31:0]                 found_flavor;
  logic [7:0]                  found_hash;
  logic [ortml_pkg::CNT_W-1:0] rule_count;

  modport source (
    output valid, status, found, found_flavor, found_hash, rule_count,
    input  ready
  );
  modport sink (
    input  valid, status, found, found_flavor, found_hash, rule_count,
    output ready
  );
endinterface

`default_nettype wire

### hdl/ortml_cmp.sv
// Shared key compare unit: merge match / stop point and lookup compatibility.
`default_nettype none

module ortml_cmp (
  input  wire logic              lookup_i,
  input  wire ortml_pkg::key_t   probe_i,
  input  wire ortml_pkg::key_t   entry_i,
  output ortml_pkg::cmp_res_t    res_o
);

  logic same_net, same_dir, probe_dir_specific, entry_dir_specific;
  logic net_ok, from_ok, to_ok;

  always_comb begin
    same_net = (probe_i.net_is_any == entry_i.net_is_any) &&
               (probe_i.net_id == entry_i.net_id);
    same_dir = (probe_i.from_part == entry_i.from_part) &&
               (probe_i.to_part == entry_i.to_part);
    probe_dir_specific = (probe_i.from_part != ortml_pkg::PART_ANY) ||
                         (probe_i.to_part != ortml_pkg::PART_ANY);
    entry_dir_specific = (entry_i.from_part != ortml_pkg::PART_ANY) ||
                         (entry_i.to_part != ortml_pkg::PART_ANY);

    net_ok  = probe_i.net_is_any || entry_i.net_is_any ||
              (entry_i.net_id == probe_i.net_id);
    from_ok = (probe_i.from_part == ortml_pkg::PART_ANY) ||
              (entry_i.from_part == ortml_pkg::PART_ANY) ||
              (entry_i.from_part == probe_i.from_part);
    to_ok   = (probe_i.to_part == ortml_pkg::PART_ANY) ||
              (entry_i.to_part == ortml_pkg::PART_ANY) ||
              (entry_i.to_part == probe_i.to_part);

    if (lookup_i) begin
      res_o.hit  = net_ok && from_ok && to_ok;
      res_o.stop = 1'b0;
    end else begin
      res_o.hit  = same_net && same_dir;
      // specific rule stops at the first wildcard entry in that respect
      res_o.stop = (!same_net && !probe_i.net_is_any && entry_i.net_is_any) ||
                   (same_net && !same_dir && probe_dir_specific && !entry_dir_specific);
    end
  end

endmodule

`default_nettype wire

### hdl/ordered_rule_table_merge_lookup.sv
// Top level: ordered wildcard rule table with merge and first-match lookup.
// Usage:
//   req_i carries one request per valid/ready handshake: func selects merge
//   (insert, overwrite or delete a rule) or lookup (first compatible rule).
//   rsp_o returns exactly one response per request: status, found flag,
//   matched flavor word and hash, and the rule count after the request.
//   One request is processed at a time; req_i.ready is high only while the
//   sequencer is idle. The table lives in a single-port-write, registered
//   read memory; one shared compare unit checks the entries one after another.
//   Each scanned entry is read (ST_SRD) and then compared (ST_SCMP); on
//   insert or delete each moved entry is read (ST_MRD) and then written
//   (ST_MWR). An insert ends by writing the new rule (ST_PUT).
//   The response sits in an output register; the next request is taken
//   while it waits, and a finished request waits only if the previous
//   response has still not been taken.
//   Reset empties the table (rule count zero); table contents need no clear.
`default_nettype none

module ordered_rule_table_merge_lookup (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ortml_req_if.sink    req_i,
  ortml_rsp_if.source  rsp_o
);

  localparam int unsigned DEPTH = ortml_pkg::TABLE_DEPTH;
  localparam int unsigned IDX_W = ortml_pkg::IDX_W;
  localparam int unsigned CNT_W = ortml_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ortml_pkg::state_e state_q, state_d;

  ortml_pkg::key_t   key_q, key_d;
  ortml_pkg::flav_t  flav_q, flav_d;
  logic              func_q, func_d;
  logic              fvalid_q, fvalid_d;
  logic              del_q, del_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  mv_q, mv_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [1:0]        status_q, status_d;
  logic              found_q, found_d;
  ortml_pkg::flav_t  fflav_q, fflav_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_status_q, out_status_d;
  logic              out_found_q, out_found_d;
  ortml_pkg::flav_t  out_flav_q, out_flav_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;

  ortml_pkg::entry_t mem [DEPTH];
  ortml_pkg::entry_t rdata_q;
  ortml_pkg::entry_t wdata;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  raddr, waddr;

  ortml_pkg::cmp_res_t cmp_res;

  ortml_cmp u_cmp (
    .lookup_i (func_q),
    .probe_i  (key_q),
    .entry_i  (rdata_q.key),
    .res_o    (cmp_res)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ortml_pkg::ST_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    flav_q       <= flav_d;
    func_q       <= func_d;
    fvalid_q     <= fvalid_d;
    del_q        <= del_d;
    idx_q        <= idx_d;
    mv_q         <= mv_d;
    status_q     <= status_d;
    found_q      <= found_d;
    fflav_q      <= fflav_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_flav_q   <= out_flav_d;
    out_count_q  <= out_count_d;
  end

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    flav_d       = flav_q;
    func_d       = func_q;
    fvalid_d     = fvalid_q;
    del_d        = del_q;
    idx_d        = idx_q;
    mv_d         = mv_q;
    held_d       = held_q;
    status_d     = status_q;
    found_d      = found_q;
    fflav_d      = fflav_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_flav_d   = out_flav_q;
    out_count_d  = out_count_q;
    rd_en        = 1'b0;
    raddr        = idx_q[IDX_W-1:0];
    wr_en        = 1'b0;
    waddr        = idx_q[IDX_W-1:0];
    wdata        = '{key: key_q, flav: flav_q};
    req_i.ready  = 1'b0;

    unique case (state_q) inside
      ortml_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          key_d.net_id     = req_i.net_is_any ? 32'd0 : req_i.net_id;
          key_d.net_is_any = req_i.net_is_any;
          key_d.from_part  = req_i.from_part;
          key_d.to_part    = req_i.to_part;
          flav_d.word      = req_i.flavor_word;
          flav_d.hash      = req_i.hash_choice;
          func_d           = req_i.func;
          fvalid_d         = req_i.flavor_valid;
          idx_d            = '0;
          status_d         = ortml_pkg::STAT_OK;
          found_d          = 1'b0;
          fflav_d          = '0;
          if (req_i.func == ortml_pkg::FUNC_LOOKUP && req_i.peer_is_loopback) begin
            state_d = ortml_pkg::ST_DONE;
          end else begin
            state_d = ortml_pkg::ST_SRD;
          end
        end
      end

      ortml_pkg::ST_SRD, ortml_pkg::ST_SCMP: begin
        // scan end: either past the last rule or at a stop point
        if ((state_q == ortml_pkg::ST_SRD && idx_q == held_q) ||
            (state_q == ortml_pkg::ST_SCMP && func_q == ortml_pkg::FUNC_MERGE &&
             !cmp_res.hit && cmp_res.stop)) begin
          if (func_q == ortml_pkg::FUNC_LOOKUP) begin
            state_d = ortml_pkg::ST_DONE;
          end else if (!fvalid_q) begin
            status_d = ortml_pkg::STAT_UNMATCHED;
            state_d  = ortml_pkg::ST_DONE;
          end else if (held_q == CNT_FULL) begin
            status_d = ortml_pkg::STAT_FULL;
            state_d  = ortml_pkg::ST_DONE;
          end else begin
            del_d   = 1'b0;
            mv_d    = held_q;
            state_d = ortml_pkg::ST_MRD;
          end
        end else if (state_q == ortml_pkg::ST_SRD) begin
          rd_en   = 1'b1;
          state_d = ortml_pkg::ST_SCMP;
        end else if (cmp_res.hit) begin
          if (func_q == ortml_pkg::FUNC_LOOKUP) begin
            found_d = 1'b1;
            fflav_d = rdata_q.flav;
            state_d = ortml_pkg::ST_DONE;
          end else if (fvalid_q) begin
            wr_en   = 1'b1;
            state_d = ortml_pkg::ST_DONE;
          end else begin
            del_d   = 1'b1;
            mv_d    = idx_q;
            state_d = ortml_pkg::ST_MRD;
          end
        end else begin
          idx_d   = idx_q + CNT_ONE;
          state_d = ortml_pkg::ST_SRD;
        end
      end

      ortml_pkg::ST_MRD: begin
        if (del_q) begin
          if (mv_q + CNT_ONE < held_q) begin
            rd_en   = 1'b1;
            raddr   = IDX_W'(mv_q + CNT_ONE);
            state_d = ortml_pkg::ST_MWR;
          end else begin
            held_d  = held_q - CNT_ONE;
            state_d = ortml_pkg::ST_DONE;
          end
        end else if (mv_q > idx_q) begin
          rd_en   = 1'b1;
          raddr   = IDX_W'(mv_q - CNT_ONE);
          state_d = ortml_pkg::ST_MWR;
        end else begin
          state_d = ortml_pkg::ST_PUT;
        end
      end

      ortml_pkg::ST_MWR: begin
        wr_en   = 1'b1;
        waddr   = mv_q[IDX_W-1:0];
        wdata   = rdata_q;
        mv_d    = del_q ? mv_q + CNT_ONE : mv_q - CNT_ONE;
        state_d = ortml_pkg::ST_MRD;
      end

      ortml_pkg::ST_PUT: begin
        wr_en   = 1'b1;
        held_d  = held_q + CNT_ONE;
        state_d = ortml_pkg::ST_DONE;
      end

      ortml_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_found_d  = found_q;
          out_flav_d   = fflav_q;
          out_count_d  = held_q;
          state_d      = ortml_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ortml_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.found_flavor = out_flav_q.word;
  assign rsp_o.found_hash   = out_flav_q.hash;
  assign rsp_o.rule_count   = out_count_q;

endmodule

`default_nettype wire
